FILE: hdl/oriented_box_overlap_test_unit_defines.svh
// Assertion macros for the oriented box overlap test unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define OBB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("obb assertion failed");

// Next-cycle implication, checked out of reset
`define OBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("obb assertion failed");

`endif

FILE: hdl/obb_pkg.sv
// Shared types, constants and fixed-point helpers of the box overlap unit.
// No dependencies; used by every module of the block.
package obb_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int COORD_BITS      = 32;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int TIDX_W          = SINE_TABLE_BITS + 1;
  localparam int SCL_W           = 40;  // extent times Q8.8 scale, rounded
  localparam int WIDE_W          = 58;  // rotation sums before rounding
  localparam int PROD_W          = COORD_BITS + 32;
  localparam int PROJ_W          = PROD_W + 1;
  localparam int S_TDATA_W       = 224;
  localparam int M_TDATA_W       = 8;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [2:0]  SEP_NONE    = 3'd4;
  localparam logic        OP_LOAD     = 1'b0;
  localparam logic        OP_TEST     = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [31:0]           axis_t;
  typedef logic [15:0]                  sine_tab_t [0:TABLE_SIZE];

  typedef struct packed {
    logic vld;
    logic load;
  } ctl_t;

  typedef struct packed {
    coord_t [3:0] cx;
    coord_t [3:0] cz;
    axis_t  [3:0] ax;
  } box_t;

  typedef struct packed {
    logic       vld;
    logic       overlap;
    logic [2:0] sep_axis;
  } res_t;

  // Quarter-wave sine in Q1.15 from a truncated Taylor sum in Q30
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k <= TABLE_SIZE; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        // divide by (2n)(2n+1) for term n
        case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          default: term = term / 64'd210;
        endcase
        if ((n & 1) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32768) v = 64'sd32768;
      t[k] = 16'(v);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  localparam logic signed [WIDE_W-1:0] COORD_HI =
    (WIDE_W'(1) <<< (COORD_BITS - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] COORD_LO = -COORD_HI - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] AXIS_HI  = WIDE_W'(64'h7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] AXIS_LO  = -AXIS_HI - WIDE_W'(1);

  // Round half up and drop 15 fraction bits
  function automatic logic signed [WIDE_W-1:0] rnd15(logic signed [WIDE_W-1:0] v);
    return (v + WIDE_W'(16384)) >>> 15;
  endfunction

  function automatic coord_t sat_coord(logic signed [WIDE_W-1:0] v);
    if (v > COORD_HI) return COORD_HI[COORD_BITS-1:0];
    if (v < COORD_LO) return COORD_LO[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  function automatic axis_t sat_axis(logic signed [WIDE_W-1:0] v);
    if (v > AXIS_HI) return AXIS_HI[31:0];
    if (v < AXIS_LO) return AXIS_LO[31:0];
    return v[31:0];
  endfunction

endpackage

FILE: hdl/obb_box.sv
// Box builder: sine lookup, scaling, rotation and translation in three stages.
// Depends on obb_pkg.
module obb_box (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  obb_pkg::ctl_t         ctl_i,
  input  logic signed [31:0]    center_x_i,
  input  logic signed [31:0]    center_z_i,
  input  logic [15:0]           scale_i,
  input  logic [15:0]           yaw_i,
  input  logic signed [31:0]    min_x_i,
  input  logic signed [31:0]    max_x_i,
  input  logic signed [31:0]    min_z_i,
  input  logic signed [31:0]    max_z_i,
  output obb_pkg::ctl_t         ctl_o,
  output obb_pkg::box_t         box_o
);
  import obb_pkg::*;

  // scale a local extent by Q8.8, round half up
  function automatic logic signed [SCL_W-1:0] scale_ext(logic signed [31:0] e,
                                                        logic [15:0] sc);
    logic signed [48:0] pr;
    pr = e * $signed({1'b0, sc});
    pr = (pr + 49'sd128) >>> 8;
    return pr[SCL_W-1:0];
  endfunction

  // table index of the sine magnitude for an angle
  function automatic logic [TIDX_W-1:0] tab_idx(logic [15:0] ang);
    logic [SINE_TABLE_BITS-1:0] p;
    p = ang[13 -: SINE_TABLE_BITS];
    return ang[14] ? TIDX_W'(TABLE_SIZE) - {1'b0, p} : {1'b0, p};
  endfunction

  ctl_t ctl1_q, ctl2_q, ctl3_q;

  // stage 1: table read and scaled extents
  logic [15:0]              smag_q, cmag_q;
  logic                     sneg_q, cneg_q;
  logic signed [SCL_W-1:0]  px_q [2];
  logic signed [SCL_W-1:0]  pz_q [2];
  logic signed [31:0]       maxx1_q, maxz1_q, cx1_q, cz1_q;
  logic [15:0]              cos_ang;

  assign cos_ang = yaw_i + 16'd16384;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      smag_q  <= SINE_TAB[tab_idx(yaw_i)];
      cmag_q  <= SINE_TAB[tab_idx(cos_ang)];
      sneg_q  <= yaw_i[15];
      cneg_q  <= cos_ang[15];
      px_q[0] <= scale_ext(max_x_i, scale_i);
      px_q[1] <= scale_ext(min_x_i, scale_i);
      pz_q[0] <= scale_ext(max_z_i, scale_i);
      pz_q[1] <= scale_ext(min_z_i, scale_i);
      maxx1_q <= max_x_i;
      maxz1_q <= max_z_i;
      cx1_q   <= center_x_i;
      cz1_q   <= center_z_i;
    end
  end

  // stage 2: rotation products
  logic signed [16:0] s_val, c_val;
  assign s_val = sneg_q ? -$signed({1'b0, smag_q}) : $signed({1'b0, smag_q});
  assign c_val = cneg_q ? -$signed({1'b0, cmag_q}) : $signed({1'b0, cmag_q});

  logic signed [56:0] cpx_q [2];
  logic signed [56:0] spx_q [2];
  logic signed [56:0] cpz_q [2];
  logic signed [56:0] spz_q [2];
  logic signed [48:0] amul_q [4];
  logic signed [31:0] cx2_q, cz2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 2; j++) begin
        cpx_q[j] <= c_val * px_q[j];
        spx_q[j] <= s_val * px_q[j];
        cpz_q[j] <= c_val * pz_q[j];
        spz_q[j] <= s_val * pz_q[j];
      end
      amul_q[0] <= c_val * maxx1_q;
      amul_q[1] <= s_val * maxx1_q;
      amul_q[2] <= s_val * maxz1_q;
      amul_q[3] <= c_val * maxz1_q;
      cx2_q <= cx1_q;
      cz2_q <= cz1_q;
    end
  end

  // stage 3: sums, rounding, translation and saturation
  box_t box_d, box_q;
  always_comb begin
    logic signed [WIDE_W-1:0] rx;
    logic signed [WIDE_W-1:0] rz;
    logic                     xi;
    logic                     zi;
    for (int i = 0; i < 4; i++) begin
      xi = i[0];
      zi = i[1];
      rx = rnd15(WIDE_W'(cpx_q[xi]) + WIDE_W'(spz_q[zi]));
      rz = rnd15(WIDE_W'(cpz_q[zi]) - WIDE_W'(spx_q[xi]));
      box_d.cx[i] = sat_coord(rx + WIDE_W'(cx2_q));
      box_d.cz[i] = sat_coord(rz + WIDE_W'(cz2_q));
    end
    box_d.ax[0] = sat_axis(rnd15(WIDE_W'(amul_q[0])));
    box_d.ax[1] = sat_axis(rnd15(-WIDE_W'(amul_q[1])));
    box_d.ax[2] = sat_axis(rnd15(WIDE_W'(amul_q[2])));
    box_d.ax[3] = sat_axis(rnd15(WIDE_W'(amul_q[3])));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) box_q <= box_d;
  end

  // advance control with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  assign ctl_o = ctl3_q;
  assign box_o = box_q;

endmodule

FILE: hdl/obb_proj.sv
// Projection and separation test of two boxes on four axes, four stages.
// Depends on obb_pkg.
module obb_proj (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  obb_pkg::box_t ref_i,
  input  obb_pkg::box_t tst_i,
  output obb_pkg::res_t res_o
);
  import obb_pkg::*;

  logic vld4_q, vld5_q, vld6_q, vld7_q;
  logic       ovl_q;
  logic [2:0] sep_q;

  // stage 4: corner by axis products, corners 0..3 reference, 4..7 test
  logic signed [PROD_W-1:0] px_q [4][8];
  logic signed [PROD_W-1:0] pz_q [4][8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 4; a++) begin
        for (int k = 0; k < 8; k++) begin
          px_q[a][k] <= PROD_W'($signed(k < 4 ? ref_i.cx[k % 4] : tst_i.cx[k % 4]))
                      * PROD_W'($signed(a < 2 ? ref_i.ax[2 * (a % 2)]
                                              : tst_i.ax[2 * (a % 2)]));
          pz_q[a][k] <= PROD_W'($signed(k < 4 ? ref_i.cz[k % 4] : tst_i.cz[k % 4]))
                      * PROD_W'($signed(a < 2 ? ref_i.ax[2 * (a % 2) + 1]
                                              : tst_i.ax[2 * (a % 2) + 1]));
        end
      end
    end
  end

  // stage 5: projections
  logic signed [PROJ_W-1:0] pj_q [4][8];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 4; a++) begin
        for (int k = 0; k < 8; k++) begin
          pj_q[a][k] <= PROJ_W'(px_q[a][k]) + PROJ_W'(pz_q[a][k]);
        end
      end
    end
  end

  // stage 6: interval ends per axis and box
  logic signed [PROJ_W-1:0] lo_d [4][2];
  logic signed [PROJ_W-1:0] hi_d [4][2];
  logic signed [PROJ_W-1:0] lo_q [4][2];
  logic signed [PROJ_W-1:0] hi_q [4][2];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 2; b++) begin
        lo_d[a][b] = pj_q[a][4 * b];
        hi_d[a][b] = pj_q[a][4 * b];
        for (int i = 1; i < 4; i++) begin
          if (pj_q[a][4 * b + i] < lo_d[a][b]) lo_d[a][b] = pj_q[a][4 * b + i];
          if (pj_q[a][4 * b + i] > hi_d[a][b]) hi_d[a][b] = pj_q[a][4 * b + i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // stage 7: first separating axis
  logic [2:0] sep_d;
  always_comb begin
    sep_d = SEP_NONE;
    for (int a = 3; a >= 0; a--) begin
      if ((hi_q[a][0] < lo_q[a][1]) || (hi_q[a][1] < lo_q[a][0])) sep_d = 3'(a);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovl_q <= (sep_d == SEP_NONE);
      sep_q <= sep_d;
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= vld_i;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
    end
  end

  assign res_o = '{vld: vld7_q, overlap: ovl_q, sep_axis: sep_q};

endmodule

FILE: hdl/oriented_box_overlap_test_unit.sv
// Oriented box overlap test unit, top level: stream ports, reference box store.
// Depends on obb_pkg, obb_box, obb_proj and the assertion macro header.
//
// Usage: each input item carries a box (centre, scale, yaw, local extents) in
// s_tdata_i and an opcode in s_tuser_i. Opcode 0 stores the box as the
// reference and gives no result; opcode 1 tests the box against the current
// reference and gives one result item on m_tdata_o (overlap flag and the
// first separating axis, 4 when none).
// Throughput: one item per cycle unless the pipeline stalls; the seven register
// stages run in lockstep. A load takes effect for a test accepted in the very
// next cycle.
// Stall: while a result waits and m_tready_i is low, the whole pipeline holds
// and s_tready_o is low; nothing is lost or repeated.
// Reset: clears all valid bits and sets the reference box to a point at the
// origin with zero axes.
`include "oriented_box_overlap_test_unit_defines.svh"

module oriented_box_overlap_test_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // center_x[31:0], center_z[63:32], scale[79:64], yaw[95:80],
  // min_x[127:96], max_x[159:128], min_z[191:160], max_z[223:192]
  input  logic [obb_pkg::S_TDATA_W-1:0]    s_tdata_i,
  // opcode[0]
  input  logic                             s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // overlap[0], separating_axis[3:1], zero fill [7:4]
  output logic [obb_pkg::M_TDATA_W-1:0]    m_tdata_o
);
  import obb_pkg::*;

  logic en;
  ctl_t in_ctl, box_ctl;
  box_t box, ref_q;
  res_t res;
  logic ld_commit;

  // hold everything while a result waits
  assign en         = !res.vld || m_tready_i;
  assign s_tready_o = en;
  assign in_ctl     = '{vld: s_tvalid_i, load: (s_tuser_i == OP_LOAD)};

  obb_box u_box (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (in_ctl),
    .center_x_i (s_tdata_i[31:0]),
    .center_z_i (s_tdata_i[63:32]),
    .scale_i    (s_tdata_i[79:64]),
    .yaw_i      (s_tdata_i[95:80]),
    .min_x_i    (s_tdata_i[127:96]),
    .max_x_i    (s_tdata_i[159:128]),
    .min_z_i    (s_tdata_i[191:160]),
    .max_z_i    (s_tdata_i[223:192]),
    .ctl_o      (box_ctl),
    .box_o      (box)
  );

  // replace the reference box when a load leaves the builder
  assign ld_commit = en && box_ctl.vld && box_ctl.load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (ld_commit) begin
      ref_q <= box;
    end
  end

  obb_proj u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (box_ctl.vld && !box_ctl.load),
    .ref_i  (ref_q),
    .tst_i  (box),
    .res_o  (res)
  );

  assign m_tvalid_o = res.vld;
  assign m_tdata_o  = {4'b0000, res.sep_axis, res.overlap};

  `OBB_ASSERT_NOW(a_overlap_axis, m_tvalid_o, m_tdata_o[0] == (m_tdata_o[3:1] == SEP_NONE))
  `OBB_ASSERT_NEXT(a_ref_load, ld_commit, ref_q == $past(box))

endmodule
